@@ hdl/zsvr_pkg.sv @@
package zsvr_pkg;

  // Grid and sample geometry
  localparam int GRID_CELLS  = 64;
  localparam int GRID_SIDE   = 8;
  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = 31;
  localparam int TOTAL_W  = 37;
  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Derived datapath widths
  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int N_W        = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int SQ_W       = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int PROD_W     = N_W + SQ_W;
  localparam int MAG_SQ_W   = 2 * SUM_W;
  localparam int NN_W       = 2 * N_W;
  localparam int FIN_W      = $clog2(GRID_CELLS + 1);
  localparam int DIV_CNT_W  = $clog2(ERR_W);

  localparam logic [ERR_W-1:0]   ERR_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST  = COUNT_W'(16);
  localparam logic               METRIC_SELECT_RST = 1'b0;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_SAMPLE_COUNT  = 1'b0,
    REG_METRIC_SELECT = 1'b1
  } reg_idx_t;

  // Item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  typedef struct packed {
    logic                op;
    logic [ROW_W-1:0]    zone_row;
    logic [COL_W-1:0]    zone_col;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic               cell_done;
    logic [ROW_W-1:0]   done_row;
    logic [COL_W-1:0]   done_col;
    logic [ERR_W-1:0]   error_value;
    logic               series_done;
    logic [TOTAL_W-1:0] error_total;
    logic               active;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic               metric_select;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic rd;
    logic upd;
    logic mul;
    logic dif;
    logic div;
    logic fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;
    logic complete;
    logic variance;
    logic div_last;
    logic out_full;
  } sts_t;

endpackage

@@ hdl/zsvr_ctrl.sv @@
module zsvr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  zsvr_pkg::sts_t  sts,
  output zsvr_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_MUL,
    S_DIF,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  // Sequencer: state, input stall and datapath commands are all registered
  always_ff @(posedge clk) begin
    zsvr_pkg::cmd_t cmd_next;
    cmd_next = '0;
    if (rst) begin
      state      <= S_IDLE;
      item_stall <= 1'b0;
      cmd        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && !item_stall) begin
            item_stall <= 1'b1;
            if (sts.skip) begin
              state        <= S_FIN;
              cmd_next.fin = 1'b1;
            end else begin
              state       <= S_READ;
              cmd_next.rd = 1'b1;
            end
          end
        end
        S_READ: begin
          state        <= S_UPD;
          cmd_next.upd = 1'b1;
        end
        S_UPD: begin
          if (sts.complete && sts.variance) begin
            state        <= S_MUL;
            cmd_next.mul = 1'b1;
          end else begin
            state        <= S_FIN;
            cmd_next.fin = 1'b1;
          end
        end
        S_MUL: begin
          state        <= S_DIF;
          cmd_next.dif = 1'b1;
        end
        S_DIF: begin
          state        <= S_DIV;
          cmd_next.div = 1'b1;
        end
        S_DIV: begin
          if (sts.div_last) begin
            state        <= S_FIN;
            cmd_next.fin = 1'b1;
          end else begin
            cmd_next.div = 1'b1;
          end
        end
        S_FIN: begin
          // hold until the result register can take the word
          if (!sts.out_full) begin
            state      <= S_IDLE;
            item_stall <= 1'b0;
          end else begin
            cmd_next.fin = 1'b1;
          end
        end
        default: begin
          state      <= S_IDLE;
          item_stall <= 1'b0;
        end
      endcase
      cmd <= cmd_next;
    end
  end

endmodule

@@ hdl/zsvr_dp.sv @@
module zsvr_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  zsvr_pkg::item_t    item,
  input  zsvr_pkg::cfg_t     cfg,
  input  zsvr_pkg::cmd_t     cmd,
  output zsvr_pkg::sts_t     sts,
  output logic               result_valid,
  input  logic               result_stall,
  output zsvr_pkg::result_t  result
);

  localparam int SB = zsvr_pkg::SAMPLE_BITS;

  typedef struct packed {
    logic [zsvr_pkg::N_W-1:0]   count;
    logic [zsvr_pkg::SUM_W-1:0] sum;
    logic [zsvr_pkg::SQ_W-1:0]  sum_sq;
    logic [SB-1:0]              low;
    logic [SB-1:0]              high;
  } row_t;

  // Captured item
  zsvr_pkg::item_t                  item_r;
  logic signed [SB-1:0]             s;
  logic [zsvr_pkg::ROW_W+zsvr_pkg::COL_W-1:0] flat_idx;
  logic [zsvr_pkg::IDX_W-1:0]       idx;

  // Cell store
  row_t                             mem [zsvr_pkg::GRID_CELLS];
  logic [zsvr_pkg::GRID_CELLS-1:0]  row_valid;
  row_t                             rd_row;
  logic                             rd_valid;
  logic signed [2*SB-1:0]           sq_full;
  logic [2*SB-1:0]                  sq_r;

  // Update stage
  logic [zsvr_pkg::N_W-1:0]         n;
  logic [zsvr_pkg::N_W-1:0]         cnt_old;
  logic [zsvr_pkg::N_W-1:0]         cnt_new;
  logic                             first;
  logic                             complete;
  logic signed [zsvr_pkg::SUM_W-1:0] s_ext;
  logic signed [zsvr_pkg::SUM_W-1:0] sum_new;
  logic [zsvr_pkg::SQ_W-1:0]        sumsq_new;
  logic signed [SB-1:0]             low_new;
  logic signed [SB-1:0]             high_new;
  logic signed [SB:0]               hi_x;
  logic signed [SB:0]               lo_x;
  logic signed [SB:0]               range_w;
  row_t                             wr_row;

  logic [zsvr_pkg::SUM_W-1:0]       sum_r;
  logic [zsvr_pkg::SQ_W-1:0]        sumsq_r;
  logic [SB:0]                      range_r;
  logic [zsvr_pkg::N_W-1:0]         n_r;
  logic                             comp_r;

  // Variance arithmetic
  logic [zsvr_pkg::SUM_W-1:0]       mag;
  logic [zsvr_pkg::PROD_W-1:0]      a_r;
  logic [zsvr_pkg::MAG_SQ_W-1:0]    b_r;
  logic [zsvr_pkg::NN_W-1:0]        nn_r;
  logic [zsvr_pkg::PROD_W-1:0]      b_x;
  logic [zsvr_pkg::PROD_W-1:0]      diff;
  logic [zsvr_pkg::PROD_W-1:0]      diff_hi;

  // Divider
  logic                             ovf_r;
  logic [zsvr_pkg::NN_W-1:0]        rem_r;
  logic [zsvr_pkg::ERR_W-1:0]       dvd_r;
  logic [zsvr_pkg::ERR_W-1:0]       q_r;
  logic [zsvr_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [zsvr_pkg::NN_W:0]          trial;
  logic [zsvr_pkg::NN_W:0]          nn_x;
  logic [zsvr_pkg::NN_W:0]          trial_sub;
  logic                             ge;

  // Series state and finish
  logic                             series_on;
  logic [zsvr_pkg::FIN_W-1:0]       fin_cnt;
  logic [zsvr_pkg::TOTAL_W-1:0]     acc;
  logic [zsvr_pkg::ERR_W-1:0]       err;
  logic [zsvr_pkg::TOTAL_W:0]       acc_sum;
  logic [zsvr_pkg::TOTAL_W-1:0]     acc_sat;
  logic [zsvr_pkg::FIN_W-1:0]       fin_inc;
  logic                             on_next;
  logic [zsvr_pkg::FIN_W-1:0]       fin_next;
  logic [zsvr_pkg::TOTAL_W-1:0]     acc_next;
  logic                             sdone;
  logic                             fin_go;
  logic                             out_full;
  zsvr_pkg::result_t                res_next;

  // Item capture on accept
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_r <= item;
    end
  end

  assign s        = $signed(item_r.sample[SB-1:0]);
  assign flat_idx = {item_r.zone_row, item_r.zone_col};
  assign idx      = flat_idx[zsvr_pkg::IDX_W-1:0];
  assign sq_full  = s * s;

  // Cell memory: read in READ, written back in UPD
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_row   <= mem[idx];
      rd_valid <= row_valid[idx];
      sq_r     <= sq_full;
    end
    if (cmd.upd) begin
      mem[idx] <= wr_row;
    end
  end

  // Per-cell written flags; an unwritten cell reads a zero count
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.upd) begin
      row_valid[idx] <= 1'b1;
    end
  end

  // Run length clamped to 1..MAX_SAMPLES
  always_comb begin
    if (cfg.sample_count == '0) begin
      n = zsvr_pkg::N_W'(1);
    end else if (cfg.sample_count > zsvr_pkg::COUNT_W'(zsvr_pkg::MAX_SAMPLES)) begin
      n = zsvr_pkg::N_W'(zsvr_pkg::MAX_SAMPLES);
    end else begin
      n = zsvr_pkg::N_W'(cfg.sample_count);
    end
  end

  // Accumulate the sample; first sample of a run loads
  always_comb begin
    cnt_old   = rd_valid ? rd_row.count : '0;
    first     = (cnt_old == '0);
    s_ext     = zsvr_pkg::SUM_W'(s);
    sum_new   = first ? s_ext : $signed(rd_row.sum) + s_ext;
    sumsq_new = first ? zsvr_pkg::SQ_W'(sq_r) : rd_row.sum_sq + zsvr_pkg::SQ_W'(sq_r);
    low_new   = (first || (s < $signed(rd_row.low)))  ? s : $signed(rd_row.low);
    high_new  = (first || (s > $signed(rd_row.high))) ? s : $signed(rd_row.high);
    cnt_new   = cnt_old + 1'b1;
    complete  = (cnt_new >= n);
    hi_x      = (SB+1)'(high_new);
    lo_x      = (SB+1)'(low_new);
    range_w   = hi_x - lo_x;
    wr_row.count  = complete ? '0 : cnt_new;
    wr_row.sum    = sum_new;
    wr_row.sum_sq = sumsq_new;
    wr_row.low    = low_new;
    wr_row.high   = high_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      sum_r   <= sum_new;
      sumsq_r <= sumsq_new;
      range_r <= range_w;
      n_r     <= n;
    end
  end

  // Completion flag, cleared for each new item
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_r <= 1'b0;
    end else if (item_valid && !item_stall) begin
      comp_r <= 1'b0;
    end else if (cmd.upd) begin
      comp_r <= complete;
    end
  end

  // Products: N*sumsq, sum^2, N^2
  assign mag = sum_r[zsvr_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      a_r  <= zsvr_pkg::PROD_W'(n_r) * zsvr_pkg::PROD_W'(sumsq_r);
      b_r  <= zsvr_pkg::MAG_SQ_W'(mag) * zsvr_pkg::MAG_SQ_W'(mag);
      nn_r <= zsvr_pkg::NN_W'(n_r) * zsvr_pkg::NN_W'(n_r);
    end
  end

  // Difference, clamped at zero, and divider setup
  assign b_x     = zsvr_pkg::PROD_W'(b_r);
  assign diff    = (a_r > b_x) ? (a_r - b_x) : '0;
  assign diff_hi = diff >> zsvr_pkg::ERR_W;

  // Restoring divider, one quotient bit per cycle; upper part checked for overflow
  assign trial     = {rem_r, dvd_r[zsvr_pkg::ERR_W-1]};
  assign nn_x      = {1'b0, nn_r};
  assign trial_sub = trial - nn_x;
  assign ge        = (trial >= nn_x);

  always_ff @(posedge clk) begin
    if (cmd.dif) begin
      ovf_r   <= (diff_hi >= zsvr_pkg::PROD_W'(nn_r));
      rem_r   <= zsvr_pkg::NN_W'(diff_hi);
      dvd_r   <= diff[zsvr_pkg::ERR_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div) begin
      rem_r   <= ge ? trial_sub[zsvr_pkg::NN_W-1:0] : trial[zsvr_pkg::NN_W-1:0];
      q_r     <= {q_r[zsvr_pkg::ERR_W-2:0], ge};
      dvd_r   <= {dvd_r[zsvr_pkg::ERR_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Error of the finished run, total and series bookkeeping
  always_comb begin
    if (!comp_r) begin
      err = '0;
    end else if (cfg.metric_select) begin
      err = ovf_r ? zsvr_pkg::ERR_MAX : q_r;
    end else begin
      err = zsvr_pkg::ERR_W'(range_r);
    end
    acc_sum = {1'b0, acc} + (zsvr_pkg::TOTAL_W+1)'(err);
    acc_sat = acc_sum[zsvr_pkg::TOTAL_W] ? zsvr_pkg::TOTAL_MAX
                                         : acc_sum[zsvr_pkg::TOTAL_W-1:0];
    fin_inc  = fin_cnt + 1'b1;
    on_next  = series_on;
    fin_next = fin_cnt;
    acc_next = acc;
    sdone    = 1'b0;
    if (item_r.op == zsvr_pkg::OP_TOGGLE) begin
      if (!series_on) begin
        on_next  = 1'b1;
        fin_next = '0;
        acc_next = '0;
      end else begin
        on_next = 1'b0;
      end
    end else if (comp_r) begin
      acc_next = acc_sat;
      fin_next = fin_inc;
      if (fin_inc == zsvr_pkg::FIN_W'(zsvr_pkg::GRID_CELLS)) begin
        sdone   = 1'b1;
        on_next = 1'b0;
      end
    end
    res_next.cell_done   = comp_r;
    res_next.done_row    = comp_r ? item_r.zone_row : '0;
    res_next.done_col    = comp_r ? item_r.zone_col : '0;
    res_next.error_value = err;
    res_next.series_done = sdone;
    res_next.error_total = acc_next;
    res_next.active      = on_next;
  end

  assign out_full = result_valid && result_stall;
  assign fin_go   = cmd.fin && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_on    <= 1'b0;
      fin_cnt      <= '0;
      acc          <= '0;
      result_valid <= 1'b0;
    end else if (fin_go) begin
      series_on    <= on_next;
      fin_cnt      <= fin_next;
      acc          <= acc_next;
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      result <= res_next;
    end
  end

  // Status to the controller
  assign sts.skip     = (item.op == zsvr_pkg::OP_TOGGLE) || !series_on;
  assign sts.complete = complete;
  assign sts.variance = cfg.metric_select;
  assign sts.div_last = (div_cnt == zsvr_pkg::DIV_CNT_W'(zsvr_pkg::ERR_W - 1));
  assign sts.out_full = out_full;

endmodule

@@ hdl/zone_series_variance_or_range_core.sv @@
// From accept to the word in the output register: a toggle or a sample outside a
// series goes straight to FIN; any other sample passes READ and UPD, and a cell completed
// in variance mode then MUL, DIF and the one-bit-per-cycle divider before FIN, which holds
// while the output is full. One item at a time: the next is taken once its word is in the output register.
// Reset (rst, synchronous): series off, totals cleared, all cell counts zero,
// sample_count 16, metric_select range.
module zone_series_variance_or_range_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [zsvr_pkg::ADDR_W-1:0]   paddr,
  input  logic [zsvr_pkg::DATA_W-1:0]   pwdata,
  output logic [zsvr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  zsvr_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output zsvr_pkg::result_t             result
);

  zsvr_pkg::cfg_t     cfg;
  zsvr_pkg::cmd_t     cmd;
  zsvr_pkg::sts_t     sts;
  zsvr_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = zsvr_pkg::reg_idx_t'(paddr[2]);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count  <= zsvr_pkg::SAMPLE_COUNT_RST;
      cfg.metric_select <= zsvr_pkg::METRIC_SELECT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        zsvr_pkg::REG_SAMPLE_COUNT:  cfg.sample_count  <= pwdata[zsvr_pkg::COUNT_W-1:0];
        zsvr_pkg::REG_METRIC_SELECT: cfg.metric_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      zsvr_pkg::REG_SAMPLE_COUNT:  prdata = zsvr_pkg::DATA_W'(cfg.sample_count);
      zsvr_pkg::REG_METRIC_SELECT: prdata = zsvr_pkg::DATA_W'(cfg.metric_select);
      default:                     prdata = '0;
    endcase
  end

  zsvr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  zsvr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ tb/sv/zone_series_variance_or_range_core_tb.sv @@
`timescale 1ns / 100ps

module zone_series_variance_or_range_core_tb;
  import zsvr_pkg::*;

  // Tracks per-cell runs and series totals, and holds the words still due
  class cell_error_board;
    logic [COUNT_W-1:0] runs_seen [GRID_CELLS];
    longint             run_sum [GRID_CELLS];
    longint unsigned    run_sum_sq [GRID_CELLS];
    int                 run_low [GRID_CELLS];
    int                 run_high [GRID_CELLS];
    bit                 on;
    int                 finished;
    longint unsigned    total;
    logic [COUNT_W-1:0] samples_per_run;
    bit                 use_variance;
    result_t            expected_words[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < GRID_CELLS; i++) begin
        runs_seen[i] = '0;
        run_sum[i] = 0;
        run_sum_sq[i] = 0;
        run_low[i] = 0;
        run_high[i] = 0;
      end
      on = 1'b0;
      finished = 0;
      total = 0;
      samples_per_run = SAMPLE_COUNT_RST;
      use_variance = METRIC_SELECT_RST;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [DATA_W-1:0] v);
      if (r == REG_SAMPLE_COUNT) samples_per_run = v[COUNT_W-1:0];
      else use_variance = v[0];
    endfunction

    // Work out the word one accepted item gives, and queue it
    function void note_item(item_t w);
      result_t         r;
      int              idx;
      int              v;
      int              n;
      longint unsigned mag;
      longint unsigned a;
      longint unsigned b;
      longint unsigned e;
      r = '0;
      if (w.op == OP_TOGGLE) begin
        if (!on) begin
          on = 1'b1;
          finished = 0;
          total = 0;
        end else begin
          on = 1'b0;
        end
      end else if (on) begin
        idx = int'({w.zone_row, w.zone_col});
        v = int'($signed(w.sample));
        n = int'(samples_per_run);
        if (n < 1) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        // first sample of a run loads, later ones accumulate
        if (runs_seen[idx] == 0) begin
          run_sum[idx] = longint'(v);
          run_sum_sq[idx] = longint'(v) * longint'(v);
          run_low[idx] = v;
          run_high[idx] = v;
        end else begin
          run_sum[idx] += longint'(v);
          run_sum_sq[idx] += longint'(v) * longint'(v);
          if (v < run_low[idx]) run_low[idx] = v;
          if (v > run_high[idx]) run_high[idx] = v;
        end
        runs_seen[idx] = runs_seen[idx] + 1'b1;
        // completes once the count reaches or passes N
        if (runs_seen[idx] >= n) begin
          if (use_variance) begin
            mag = (run_sum[idx] < 0) ? -run_sum[idx] : run_sum[idx];
            a = longint'(n) * run_sum_sq[idx];
            b = mag * mag;
            e = (a > b) ? (a - b) / longint'(n * n) : 64'd0;
          end else begin
            e = longint'(run_high[idx]) - longint'(run_low[idx]);
          end
          if (e > ERR_MAX) e = 64'(ERR_MAX);
          runs_seen[idx] = '0;
          r.cell_done = 1'b1;
          r.done_row = w.zone_row;
          r.done_col = w.zone_col;
          r.error_value = e[ERR_W-1:0];
          total += e;
          if (total > TOTAL_MAX) total = 64'(TOTAL_MAX);
          finished++;
          if (finished >= GRID_CELLS) begin
            r.series_done = 1'b1;
            on = 1'b0;
          end
        end
      end
      r.error_total = total[TOTAL_W-1:0];
      r.active = on;
      expected_words.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $write("%0t: %s: exp done=%0d rc=%0d,%0d err=%0d sdone=%0d tot=%0d act=%0d",
               $realtime, what,
               want.cell_done, want.done_row, want.done_col, want.error_value,
               want.series_done, want.error_total, want.active);
        $display(" | got done=%0d rc=%0d,%0d err=%0d sdone=%0d tot=%0d act=%0d",
                 got.cell_done, got.done_row, got.done_col, got.error_value,
                 got.series_done, got.error_total, got.active);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report("word with nothing due", '0, got);
        return;
      end
      want = expected_words.pop_front();
      if (got.cell_done !== want.cell_done || got.done_row !== want.done_row ||
          got.done_col !== want.done_col || got.error_value !== want.error_value ||
          got.series_done !== want.series_done || got.error_total !== want.error_total ||
          got.active !== want.active)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;

  cell_error_board board;
  int              src_idle_pct = 0;
  int              snk_stall_pct = 0;
  int              hot_cells [4];
  int              hot_count = 4;
  int              base_mm = 0;

  zone_series_variance_or_range_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < snk_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_word(result);
  end

  task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(r, v);
  endtask

  task automatic wait_drained();
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One word on the input channel; called right after posedge clk
  task automatic send_word(item_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(w);
  endtask

  task automatic sample_at(int row, int col, int mm);
    item_t w;
    w.op = OP_SAMPLE;
    w.zone_row = row[ROW_W-1:0];
    w.zone_col = col[COL_W-1:0];
    w.sample = mm[SAMPLE_W-1:0];
    send_word(w);
  endtask

  task automatic toggle();
    item_t w;
    w = $bits(item_t)'($urandom());
    w.op = OP_TOGGLE;
    send_word(w);
  endtask

  // Mostly samples into a live series, aimed at a few hot cells
  function automatic item_t make_word();
    item_t w;
    int    pick;
    int    pick_cell;
    w = $bits(item_t)'($urandom());
    if (!board.on) begin
      w.op = ($urandom_range(9) == 0) ? OP_SAMPLE : OP_TOGGLE;
      return w;
    end
    if ($urandom_range(99) == 0) begin
      w.op = OP_TOGGLE;
      return w;
    end
    w.op = OP_SAMPLE;
    if ($urandom_range(99) < 60) begin
      pick_cell = hot_cells[$urandom_range(hot_count - 1)];
      {w.zone_row, w.zone_col} = pick_cell[IDX_W-1:0];
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: w.sample = 16'h8000;
        1: w.sample = 16'h7fff;
        2: w.sample = 16'h0000;
        default: w.sample = 16'hffff;
      endcase
    end else if (pick < 60) begin
      w.sample = SAMPLE_W'(base_mm + $signed($urandom_range(200)) - 100);
    end else begin
      w.sample = SAMPLE_W'($urandom_range(16'hffff));
    end
    return w;
  endfunction

  task automatic run_phase(int quota, int runs, bit variance);
    item_t w;
    int    done_items;
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, runs);
    write_reg(REG_METRIC_SELECT, DATA_W'(variance));
    hot_count = (runs >= 16) ? 1 : 4;
    for (int i = 0; i < 4; i++) hot_cells[i] = $urandom_range(GRID_CELLS - 1);
    base_mm = $signed($urandom_range(60000)) - 30000;
    done_items = 0;
    while (done_items < quota) begin
      // now and then hold off until the block has caught up
      if ($urandom_range(149) == 0) begin
        item_valid <= 1'b0;
        wait_drained();
      end
      w = make_word();
      if (w.op == OP_TOGGLE || board.on) done_items++;
      send_word(w);
    end
  endtask

  initial begin : stimulus
    int phase_runs [12];
    int k;
    phase_runs = '{1, 64, 0, 127, 2, 3, 1, 5, 16, 4, 2, 1};
    board = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_valid <= 1'b0;
    item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one-sample runs at the field extremes, toggles, ignored samples
    write_reg(REG_SAMPLE_COUNT, 1);
    write_reg(REG_METRIC_SELECT, 0);
    sample_at(7, 7, -32768);
    toggle();
    sample_at(0, 0, -32768);
    sample_at(7, 7, 32767);
    sample_at(0, 7, 0);
    sample_at(7, 0, -1);
    toggle();
    sample_at(3, 3, 5);
    toggle();
    item_valid <= 1'b0;
    wait_drained();
    // variance of full-scale pairs
    write_reg(REG_SAMPLE_COUNT, 2);
    write_reg(REG_METRIC_SELECT, 1);
    sample_at(3, 4, 32767);
    sample_at(3, 4, -32768);
    sample_at(5, 2, -32768);
    sample_at(5, 2, -32768);
    item_valid <= 1'b0;
    wait_drained();
    // widest range
    write_reg(REG_METRIC_SELECT, 0);
    sample_at(1, 1, -32768);
    sample_at(1, 1, 32767);
    item_valid <= 1'b0;
    wait_drained();
    // run length lowered while a cell is part way through
    write_reg(REG_SAMPLE_COUNT, 4);
    sample_at(2, 2, 100);
    sample_at(2, 2, -5);
    sample_at(2, 2, 7);
    item_valid <= 1'b0;
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, 2);
    sample_at(2, 2, 3);
    item_valid <= 1'b0;
    wait_drained();
    // zero run length acts as one
    write_reg(REG_SAMPLE_COUNT, 0);
    sample_at(6, 6, 12);
    item_valid <= 1'b0;

    // random: three idling regimes, four settings each
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        src_idle_pct = 22;
        snk_stall_pct = 62;
      end else if (p < 8) begin
        src_idle_pct = 62;
        snk_stall_pct = 22;
      end else begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      run_phase(117, phase_runs[p], p[0]);
      item_valid <= 1'b0;
    end

    // let the last words out, with a bound
    for (k = 0; k < 4000 && board.expected_words.size() != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.expected_words.size() != 0) begin
      $display("%0t: %0d words never arrived", $realtime, board.expected_words.size());
      board.mismatches += board.expected_words.size();
    end
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
